### hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// what must hold in the cycle after reset
`define ASSERT_AFTER_RESET(lbl, clk, rst, post, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (post)) else $error(msg);

`endif

### hdl/lsbspi_pkg.sv
// types, codes and constants of the lsb-first spi register master
package lsbspi_pkg;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ_WORD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE_WORD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ENTER      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LEAVE      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY  = 2'd2;

  localparam logic [7:0]  HALF_PERIOD_RST = 8'd1;
  localparam logic [23:0] SHORT_DELAY_RST = 24'd100000;
  localparam logic [23:0] LONG_DELAY_RST  = 24'd1000000;

  localparam logic [7:0] DUMMY_BYTE = 8'hff;
  localparam logic [1:0] OP_READ    = 2'b01;
  localparam logic [1:0] OP_WRITE   = 2'b10;

  // bit positions in the result tdata
  localparam int O_SELECT_N = 0;
  localparam int O_BUSY     = 5;
  localparam int O_DONE     = 6;
  localparam int O_REJECTED = 39;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_HIGH    = 7'b0000010,
    PH_LOW     = 7'b0000100,
    PH_ENTER_A = 7'b0001000,
    PH_ENTER_B = 7'b0010000,
    PH_ENTER_C = 7'b0100000,
    PH_LEAVE_A = 7'b1000000
  } phase_t;

endpackage

### hdl/lsb_first_spi_register_master.sv
// timed lsb-first spi register master with mode-pin sequencer, one tick per request
//
//  channel   | direction | request / payload
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one tick: kind in tuser, address, write word, miso
//  m_axis    | out       | pin levels, busy, done, read word, rejected
//  cfg       | in        | register index and value (half period, delays)
//
//  one request a clock while the output register is empty or being drained:
//  state and result register are both loaded at the accepting edge
//  a stalled result holds the input side only while m_axis_tready is low
//  rst is synchronous; pins come up with select, clock, eject, aux high
//  configuration writes are ready whenever rst is low
module lsb_first_spi_register_master (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // reg_addr [5:0], write_data [37:6], miso [38], zero pad [39]
  input  logic [lsbspi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind [2:0]
  input  logic [lsbspi_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // select_n [0], sclk [1], mosi [2], eject_pin [3], aux_pin [4],
  // busy_res [5], done_res [6], read_data [38:7], rejected [39]
  output logic [lsbspi_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsbspi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsbspi_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import lsbspi_pkg::*;

  // request fields
  logic [KIND_W-1:0] kind;
  logic [5:0]        reg_addr;
  logic [31:0]       write_data;
  logic              miso;

  // configuration registers
  logic [7:0]  half_period_ticks;
  logic [23:0] short_delay_ticks;
  logic [23:0] long_delay_ticks;

  // sequencer state
  phase_t      phase, phase_next;
  logic [2:0]  active_command, active_command_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  half_timer, half_timer_next;
  logic [23:0] delay_timer, delay_timer_next;
  logic [7:0]  shift_out, shift_out_next;
  logic [31:0] held_write_word, held_write_word_next;
  logic [31:0] read_accumulator, read_accumulator_next;
  logic        select_n, select_n_next;
  logic        sclk, sclk_next;
  logic        mosi, mosi_next;
  logic        eject_pin, eject_pin_next;
  logic        aux_pin, aux_pin_next;
  logic        done_next, rejected_next;

  // helpers
  logic        accept;
  logic        is_cmd;
  logic        is_read;
  logic [7:0]  half_load;
  logic [23:0] short_load;
  logic [23:0] long_load;
  logic [7:0]  cmd_byte;
  logic [2:0]  total_bytes;
  logic [2:0]  byte_inc;
  logic [2:0]  rd_byte;
  logic [1:0]  wr_sel;
  logic [4:0]  rd_shift;
  logic [7:0]  shifted;
  logic [7:0]  next_byte;

  assign kind       = s_axis_tuser;
  assign reg_addr   = s_axis_tdata[5:0];
  assign write_data = s_axis_tdata[37:6];
  assign miso       = s_axis_tdata[38];

  // output register frees the input whenever it is empty or being drained
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = !rst;

  // a zero timing value counts as one tick
  assign half_load  = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
  assign short_load = (short_delay_ticks == 24'd0) ? 24'd1 : short_delay_ticks;
  assign long_load  = (long_delay_ticks == 24'd0) ? 24'd1 : long_delay_ticks;

  assign is_cmd  = kind inside {[KIND_READ_WORD:KIND_LEAVE]};
  assign is_read = (active_command == KIND_READ_WORD) || (active_command == KIND_READ_BYTE);

  // command byte for a starting transfer
  assign cmd_byte = {reg_addr, (kind == KIND_WRITE_WORD) ? OP_WRITE : OP_READ};

  always_comb begin
    case (active_command)
      KIND_READ_WORD: total_bytes = 3'd6;
      KIND_READ_BYTE: total_bytes = 3'd3;
      default:        total_bytes = 3'd5;
    endcase
  end

  // byte and bit position of a sampled read bit, lsb first
  assign rd_byte  = byte_count - 3'd2;
  assign rd_shift = {rd_byte[1:0], bit_count};

  // next byte to shift out after a byte boundary
  assign byte_inc  = byte_count + 3'd1;
  assign wr_sel    = 2'(byte_inc - 3'd1);
  assign shifted   = shift_out >> 1;
  assign next_byte = is_read ? ((byte_inc == 3'd1) ? DUMMY_BYTE : 8'd0)
                             : 8'(held_write_word >> {wr_sel, 3'b000});

  always_comb begin
    phase_next            = phase;
    active_command_next   = active_command;
    bit_count_next        = bit_count;
    byte_count_next       = byte_count;
    half_timer_next       = half_timer;
    delay_timer_next      = delay_timer;
    shift_out_next        = shift_out;
    held_write_word_next  = held_write_word;
    read_accumulator_next = read_accumulator;
    select_n_next         = select_n;
    sclk_next             = sclk;
    mosi_next             = mosi;
    eject_pin_next        = eject_pin;
    aux_pin_next          = aux_pin;
    done_next             = 1'b0;
    rejected_next         = (phase != PH_IDLE) && is_cmd;

    case (phase)
      PH_IDLE: begin
        if (is_cmd) begin
          active_command_next = kind;
          case (kind)
            KIND_ENTER: begin
              aux_pin_next     = 1'b0;
              delay_timer_next = short_load;
              phase_next       = PH_ENTER_A;
            end
            KIND_LEAVE: begin
              select_n_next    = 1'b1;
              eject_pin_next   = 1'b0;
              delay_timer_next = short_load;
              phase_next       = PH_LEAVE_A;
            end
            default: begin
              // register access: select low, first command bit goes out
              if (kind == KIND_WRITE_WORD) begin
                held_write_word_next = write_data;
              end else begin
                read_accumulator_next = '0;
              end
              shift_out_next  = cmd_byte;
              bit_count_next  = 3'd0;
              byte_count_next = 3'd0;
              select_n_next   = 1'b0;
              mosi_next       = cmd_byte[0];
              sclk_next       = 1'b1;
              half_timer_next = half_load;
              phase_next      = PH_HIGH;
            end
          endcase
        end
      end
      PH_HIGH: begin
        if (half_timer > 8'd1) begin
          half_timer_next = half_timer - 8'd1;
        end else begin
          // miso sampled at the end of the high half
          if (is_read && byte_count >= 3'd2) begin
            read_accumulator_next = read_accumulator | (32'(miso) << rd_shift);
          end
          sclk_next       = 1'b0;
          half_timer_next = half_load;
          phase_next      = PH_LOW;
        end
      end
      PH_LOW: begin
        if (half_timer > 8'd1) begin
          half_timer_next = half_timer - 8'd1;
        end else if (bit_count < 3'd7) begin
          bit_count_next  = bit_count + 3'd1;
          shift_out_next  = shifted;
          mosi_next       = shifted[0];
          sclk_next       = 1'b1;
          half_timer_next = half_load;
          phase_next      = PH_HIGH;
        end else begin
          bit_count_next  = 3'd0;
          byte_count_next = byte_inc;
          if (byte_inc >= total_bytes) begin
            shift_out_next = shifted;
            select_n_next  = 1'b1;
            phase_next     = PH_IDLE;
            done_next      = 1'b1;
          end else begin
            shift_out_next  = next_byte;
            mosi_next       = next_byte[0];
            sclk_next       = 1'b1;
            half_timer_next = half_load;
            phase_next      = PH_HIGH;
          end
        end
      end
      PH_ENTER_A: begin
        if (delay_timer > 24'd1) begin
          delay_timer_next = delay_timer - 24'd1;
        end else begin
          select_n_next    = 1'b0;
          eject_pin_next   = 1'b0;
          delay_timer_next = short_load;
          phase_next       = PH_ENTER_B;
        end
      end
      PH_ENTER_B: begin
        if (delay_timer > 24'd1) begin
          delay_timer_next = delay_timer - 24'd1;
        end else begin
          aux_pin_next     = 1'b1;
          eject_pin_next   = 1'b1;
          delay_timer_next = long_load;
          phase_next       = PH_ENTER_C;
        end
      end
      PH_ENTER_C: begin
        if (delay_timer > 24'd1) begin
          delay_timer_next = delay_timer - 24'd1;
        end else begin
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end
      end
      PH_LEAVE_A: begin
        if (delay_timer > 24'd1) begin
          delay_timer_next = delay_timer - 24'd1;
        end else begin
          aux_pin_next   = 1'b0;
          eject_pin_next = 1'b1;
          phase_next     = PH_IDLE;
          done_next      = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      short_delay_ticks <= SHORT_DELAY_RST;
      long_delay_ticks  <= LONG_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data[7:0];
        CFG_SHORT_DELAY: short_delay_ticks <= cfg_data;
        CFG_LONG_DELAY:  long_delay_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      active_command   <= KIND_TICK;
      bit_count        <= 3'd0;
      byte_count       <= 3'd0;
      half_timer       <= 8'd0;
      delay_timer      <= 24'd0;
      shift_out        <= 8'd0;
      held_write_word  <= 32'd0;
      read_accumulator <= 32'd0;
      select_n         <= 1'b1;
      sclk             <= 1'b1;
      mosi             <= 1'b0;
      eject_pin        <= 1'b1;
      aux_pin          <= 1'b1;
    end else if (accept) begin
      phase            <= phase_next;
      active_command   <= active_command_next;
      bit_count        <= bit_count_next;
      byte_count       <= byte_count_next;
      half_timer       <= half_timer_next;
      delay_timer      <= delay_timer_next;
      shift_out        <= shift_out_next;
      held_write_word  <= held_write_word_next;
      read_accumulator <= read_accumulator_next;
      select_n         <= select_n_next;
      sclk             <= sclk_next;
      mosi             <= mosi_next;
      eject_pin        <= eject_pin_next;
      aux_pin          <= aux_pin_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {rejected_next, read_accumulator_next, done_next,
                       phase_next != PH_IDLE, aux_pin_next, eject_pin_next,
                       mosi_next, sclk_next, select_n_next};
    end
  end

endmodule

### hdl/lsbspi_checker.sv
// port-level checker for the spi register master, bound to the top level
`include "assert_macros.svh"

module lsbspi_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lsbspi_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import lsbspi_pkg::*;

  // every accepted request yields a result in the next cycle
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted request gave no result")

  // an empty output register never blocks the input side
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // a stalled result holds
  `ASSERT_NEXT(a_result_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // a finishing command is never reported as still running
  `ASSERT_IMPLIES(a_done_not_busy, clk, rst, m_axis_tvalid && m_axis_tdata[O_DONE], !m_axis_tdata[O_BUSY], "done reported while busy")

  // no result straight out of reset
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !m_axis_tvalid, "result valid after reset")

endmodule

bind lsb_first_spi_register_master lsbspi_checker u_checker (.*);

### tb/sv/lsbspi_tb_pkg.sv
// scoreboard and pin-level predictor for the lsb-first spi register master bench
package lsbspi_tb_pkg;
  import lsbspi_pkg::*;

  // kinds the block treats as a plain tick
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // result fields not named in the block package
  localparam int O_SCLK    = 1;
  localparam int O_MOSI    = 2;
  localparam int O_EJECT   = 3;
  localparam int O_AUX     = 4;
  localparam int O_READ_LO = 7;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [5:0]        reg_addr;
    logic [31:0]       write_data;
    logic              miso;
  } tick_req_t;

  typedef struct {
    logic        select_n;
    logic        sclk;
    logic        mosi;
    logic        eject_pin;
    logic        aux_pin;
    logic        busy;
    logic        done;
    logic [31:0] read_data;
    logic        rejected;
  } pin_result_t;

  class spi_tick_scoreboard;
    logic [7:0]        half_period;
    logic [23:0]       short_delay;
    logic [23:0]       long_delay;
    phase_t            seq_phase;
    logic [KIND_W-1:0] cur_kind;
    int                bit_idx;
    int                byte_idx;
    logic [7:0]        half_cnt;
    logic [23:0]       delay_cnt;
    logic [7:0]        shifter;
    logic [31:0]       wr_word;
    logic [31:0]       rd_word;
    logic              sel_n;
    logic              sclk;
    logic              mosi;
    logic              eject;
    logic              aux;
    pin_result_t       expected_pins[$];
    int                failures;
    int                results_seen;

    function new();
      half_period  = HALF_PERIOD_RST;
      short_delay  = SHORT_DELAY_RST;
      long_delay   = LONG_DELAY_RST;
      seq_phase    = PH_IDLE;
      cur_kind     = KIND_TICK;
      bit_idx      = 0;
      byte_idx     = 0;
      half_cnt     = '0;
      delay_cnt    = '0;
      shifter      = '0;
      wr_word      = '0;
      rd_word      = '0;
      sel_n        = 1'b1;
      sclk         = 1'b1;
      mosi         = 1'b0;
      eject        = 1'b1;
      aux          = 1'b1;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        CFG_HALF_PERIOD: half_period = value[7:0];
        CFG_SHORT_DELAY: short_delay = value;
        CFG_LONG_DELAY:  long_delay  = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function bit busy();
      return seq_phase != PH_IDLE;
    endfunction

    function bit reading();
      return cur_kind == KIND_READ_WORD || cur_kind == KIND_READ_BYTE;
    endfunction

    function int frame_bytes();
      if (cur_kind == KIND_READ_WORD) return 6;
      if (cur_kind == KIND_READ_BYTE) return 3;
      return 5;
    endfunction

    function logic [7:0] next_byte(int idx);
      if (reading()) return idx == 1 ? DUMMY_BYTE : 8'h00;
      return wr_word[8 * ((idx - 1) % 4) +: 8];
    endfunction

    // zero in a timing register counts as one tick
    function void load_delay(logic [23:0] ticks);
      delay_cnt = (ticks == '0) ? 24'd1 : ticks;
    endfunction

    function void start_bit();
      mosi      = shifter[0];
      sclk      = 1'b1;
      half_cnt  = (half_period == '0) ? 8'd1 : half_period;
      seq_phase = PH_HIGH;
    endfunction

    function void note_request(tick_req_t r);
      pin_result_t res;
      bit          is_cmd;
      bit          rej;
      bit          fin;
      is_cmd = r.kind >= KIND_READ_WORD && r.kind <= KIND_LEAVE;
      rej = 1'b0;
      fin = 1'b0;
      if (seq_phase == PH_IDLE) begin
        if (is_cmd) begin
          cur_kind = r.kind;
          case (r.kind)
            KIND_ENTER: begin
              aux = 1'b0;
              load_delay(short_delay);
              seq_phase = PH_ENTER_A;
            end
            KIND_LEAVE: begin
              sel_n = 1'b1;
              eject = 1'b0;
              load_delay(short_delay);
              seq_phase = PH_LEAVE_A;
            end
            default: begin
              if (reading()) rd_word = '0;
              else wr_word = r.write_data;
              shifter  = {r.reg_addr, reading() ? OP_READ : OP_WRITE};
              bit_idx  = 0;
              byte_idx = 0;
              sel_n    = 1'b0;
              start_bit();
            end
          endcase
        end
      end else begin
        rej = is_cmd;
        case (seq_phase)
          PH_HIGH: begin
            if (half_cnt > 8'd1) begin
              half_cnt--;
            end else begin
              // miso as it stands at the end of the high half
              if (reading() && byte_idx >= 2)
                rd_word[8 * ((byte_idx - 2) % 4) + bit_idx] =
                  rd_word[8 * ((byte_idx - 2) % 4) + bit_idx] | r.miso;
              sclk      = 1'b0;
              half_cnt  = (half_period == '0) ? 8'd1 : half_period;
              seq_phase = PH_LOW;
            end
          end
          PH_LOW: begin
            if (half_cnt > 8'd1) begin
              half_cnt--;
            end else begin
              shifter = shifter >> 1;
              if (bit_idx < 7) begin
                bit_idx++;
                start_bit();
              end else begin
                bit_idx = 0;
                byte_idx++;
                if (byte_idx >= frame_bytes()) begin
                  sel_n     = 1'b1;
                  seq_phase = PH_IDLE;
                  fin       = 1'b1;
                end else begin
                  shifter = next_byte(byte_idx);
                  start_bit();
                end
              end
            end
          end
          PH_ENTER_A: begin
            if (delay_cnt > 24'd1) begin
              delay_cnt--;
            end else begin
              sel_n = 1'b0;
              eject = 1'b0;
              load_delay(short_delay);
              seq_phase = PH_ENTER_B;
            end
          end
          PH_ENTER_B: begin
            if (delay_cnt > 24'd1) begin
              delay_cnt--;
            end else begin
              aux   = 1'b1;
              eject = 1'b1;
              load_delay(long_delay);
              seq_phase = PH_ENTER_C;
            end
          end
          PH_ENTER_C: begin
            if (delay_cnt > 24'd1) begin
              delay_cnt--;
            end else begin
              seq_phase = PH_IDLE;
              fin       = 1'b1;
            end
          end
          PH_LEAVE_A: begin
            if (delay_cnt > 24'd1) begin
              delay_cnt--;
            end else begin
              aux       = 1'b0;
              eject     = 1'b1;
              seq_phase = PH_IDLE;
              fin       = 1'b1;
            end
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
      res.select_n  = sel_n;
      res.sclk      = sclk;
      res.mosi      = mosi;
      res.eject_pin = eject;
      res.aux_pin   = aux;
      res.busy      = seq_phase != PH_IDLE;
      res.done      = fin;
      res.read_data = rd_word;
      res.rejected  = rej;
      expected_pins.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] td);
      pin_result_t want;
      if (expected_pins.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result %h arrived with nothing outstanding", td);
        return;
      end
      want = expected_pins.pop_front();
      compare_field("select_n", 32'(want.select_n), 32'(td[O_SELECT_N]));
      compare_field("sclk", 32'(want.sclk), 32'(td[O_SCLK]));
      compare_field("mosi", 32'(want.mosi), 32'(td[O_MOSI]));
      compare_field("eject_pin", 32'(want.eject_pin), 32'(td[O_EJECT]));
      compare_field("aux_pin", 32'(want.aux_pin), 32'(td[O_AUX]));
      compare_field("busy_res", 32'(want.busy), 32'(td[O_BUSY]));
      compare_field("done_res", 32'(want.done), 32'(td[O_DONE]));
      compare_field("read_data", want.read_data, td[O_READ_LO +: 32]);
      compare_field("rejected", 32'(want.rejected), 32'(td[O_REJECTED]));
      results_seen++;
    endfunction
  endclass

endpackage

### tb/sv/tb_lsb_first_spi_register_master.sv
// self-checking bench for the lsb-first spi register master, directed then random ticks
module tb_lsb_first_spi_register_master;
  import lsbspi_pkg::*;
  import lsbspi_tb_pkg::*;

  // far above the slowest legal run
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_CYCLES  = 300;

  // miso level while a directed command is clocked out
  localparam int MISO_LOW    = 0;
  localparam int MISO_HIGH   = 1;
  localparam int MISO_RANDOM = 2;

  // flow-control modes of a phase
  localparam int FLOW_FREE      = 0;
  localparam int FLOW_SEND_IDLE = 1;
  localparam int FLOW_RECV_STALL = 2;
  localparam int FLOW_BOTH      = 3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [KIND_W-1:0]    s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_goal   = 0;  // raised by the stimulus to ask for a long hold-off
  int hold_count  = 0;  // cycles of hold-off served so far
  int cycle_count = 0;

  spi_tick_scoreboard pins_sb;

  lsb_first_spi_register_master i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lsb_first_spi_register_master: FAILED **");
      $finish;
    end
  end

  // result side: a long hold-off when asked for, otherwise random stalls
  always @(posedge clk) begin
    if (hold_count < hold_goal) begin
      m_axis_tready <= 1'b0;
      hold_count++;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted result goes against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) pins_sb.check_result(m_axis_tdata);
  end

  function automatic tick_req_t make_request(logic [KIND_W-1:0] kind, logic [5:0] addr,
                                             logic [31:0] data, logic miso);
    tick_req_t r;
    r.kind       = kind;
    r.reg_addr   = addr;
    r.write_data = data;
    r.miso       = miso;
    return r;
  endfunction

  // one of the real commands; top limits how far down the list it may reach
  function automatic logic [KIND_W-1:0] pick_command(int top);
    case ($urandom_range(top))
      0:       return KIND_READ_WORD;
      1:       return KIND_READ_BYTE;
      2:       return KIND_WRITE_WORD;
      3:       return KIND_ENTER;
      default: return KIND_LEAVE;
    endcase
  endfunction

  // mostly well-formed traffic: a new command soon after the sequencer goes idle,
  // plain ticks while it works, with a sprinkling of spare kinds and rejected requests
  function automatic tick_req_t random_request(bit seq_busy, bit allow_mode);
    tick_req_t r;
    int        roll;
    int        word_roll;
    r.reg_addr = 6'($urandom_range(63));
    r.miso     = 1'($urandom_range(1));
    word_roll  = $urandom_range(9);
    r.write_data = (word_roll == 0) ? 32'h0000_0000 :
                   (word_roll == 1) ? 32'hffff_ffff : $urandom;
    roll = $urandom_range(99);
    if (!seq_busy) begin
      if (roll < 40) r.kind = pick_command(allow_mode ? 4 : 2);
      else if (roll < 46) r.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      else r.kind = KIND_TICK;
    end else begin
      if (roll < 4) r.kind = pick_command(4);
      else if (roll < 8) r.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      else r.kind = KIND_TICK;
    end
    return r;
  endfunction

  // offers one request, with random gaps ahead of it, and waits for the handshake
  task automatic send_request(input tick_req_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.miso, r.write_data, r.reg_addr};
    s_axis_tuser  <= r.kind;
    do @(posedge clk); while (!s_axis_tready);
    pins_sb.note_request(r);
  endtask

  // plain ticks until the predicted sequencer is back in idle
  task automatic finish_command(input int miso_mode);
    logic level;
    while (pins_sb.busy()) begin
      level = (miso_mode == MISO_RANDOM) ? logic'($urandom_range(1)) : (miso_mode == MISO_HIGH);
      send_request(make_request(KIND_TICK, 6'($urandom_range(63)), $urandom, level));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pins_sb.pending() != 0) @(posedge clk);
  endtask

  // all three timing registers plus the unused index, once every result is back
  task automatic set_timing(input logic [23:0] half, input logic [23:0] short_d,
                            input logic [23:0] long_d);
    logic [CFG_IDX_W-1:0] idxs [4];
    logic [CFG_DAT_W-1:0] vals [4];
    idxs = '{CFG_HALF_PERIOD, CFG_SHORT_DELAY, CFG_LONG_DELAY, CFG_UNUSED};
    vals = '{half, short_d, long_d, 24'($urandom)};
    drain();
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      pins_sb.set_register(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_flow(input int flow);
    idle_pct  = (flow == FLOW_SEND_IDLE) ? 74 : (flow == FLOW_BOTH) ? 33 : 0;
    stall_pct = (flow == FLOW_RECV_STALL) ? 74 : (flow == FLOW_BOTH) ? 33 : 0;
  endtask

  task automatic run_phase(input int flow, input bit allow_mode, input int hold_cycles,
                           input logic [23:0] half, input logic [23:0] short_d,
                           input logic [23:0] long_d);
    set_timing(half, short_d, long_d);
    set_flow(flow);
    hold_goal = hold_count + hold_cycles;
    repeat (RANDOM_ITEMS) send_request(random_request(pins_sb.busy(), allow_mode));
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_TICK;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_HALF_PERIOD;
    cfg_data      <= '0;
    pins_sb = new();
    set_flow(FLOW_FREE);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // read word on the timing left by reset, top register number
    send_request(make_request(KIND_READ_WORD, 6'd63, 32'h0, 1'b0));
    finish_command(MISO_RANDOM);

    // half period masks down to zero, delays zero: all count as one tick
    set_timing(24'h123400, 24'd0, 24'd0);
    send_request(make_request(KIND_WRITE_WORD, 6'd63, 32'hffff_ffff, 1'b0));
    // requests while the write runs are turned away, spare kinds pass as ticks
    send_request(make_request(KIND_READ_WORD, 6'd1, 32'h0, 1'b1));
    send_request(make_request(KIND_ENTER, 6'd2, 32'h0, 1'b0));
    send_request(make_request(KIND_SPARE_LO, 6'd3, 32'h0, 1'b1));
    send_request(make_request(KIND_SPARE_HI, 6'd4, 32'h0, 1'b0));
    send_request(make_request(KIND_LEAVE, 6'd5, 32'h0, 1'b1));
    send_request(make_request(KIND_WRITE_WORD, 6'd6, 32'h0, 1'b0));
    finish_command(MISO_RANDOM);
    send_request(make_request(KIND_WRITE_WORD, 6'd0, 32'h0000_0000, 1'b0));
    finish_command(MISO_LOW);
    send_request(make_request(KIND_WRITE_WORD, 6'd21, 32'ha5c3_0f96, 1'b1));
    finish_command(MISO_RANDOM);
    // read byte with miso stuck high: only the low byte may fill
    send_request(make_request(KIND_READ_BYTE, 6'd0, 32'h0, 1'b1));
    finish_command(MISO_HIGH);
    send_request(make_request(KIND_READ_WORD, 6'd42, 32'h0, 1'b1));
    finish_command(MISO_HIGH);
    send_request(make_request(KIND_READ_WORD, 6'd63, 32'h0, 1'b0));
    finish_command(MISO_LOW);
    // mode sequences with the shortest waits
    send_request(make_request(KIND_ENTER, 6'd0, 32'h0, 1'b0));
    finish_command(MISO_RANDOM);
    send_request(make_request(KIND_LEAVE, 6'd63, 32'h0, 1'b1));
    finish_command(MISO_RANDOM);
    send_request(make_request(KIND_SPARE_HI, 6'd9, 32'h0, 1'b1));
    send_request(make_request(KIND_SPARE_LO, 6'd9, 32'h0, 1'b0));
    // longer waits and a leave request turned away halfway through an enter
    set_timing(24'd2, 24'd3, 24'd5);
    send_request(make_request(KIND_ENTER, 6'd7, 32'h0, 1'b0));
    send_request(make_request(KIND_TICK, 6'd7, 32'h0, 1'b0));
    send_request(make_request(KIND_LEAVE, 6'd7, 32'h0, 1'b1));
    finish_command(MISO_RANDOM);
    send_request(make_request(KIND_LEAVE, 6'd8, 32'h0, 1'b1));
    finish_command(MISO_RANDOM);

    // random traffic through every flow mode and a spread of timing settings
    run_phase(FLOW_FREE, 1'b1, 0, 24'd1, 24'd3, 24'd5);
    run_phase(FLOW_SEND_IDLE, 1'b1, 0, 24'd2, 24'd1, 24'd2);
    run_phase(FLOW_RECV_STALL, 1'b1, 0, 24'd3, 24'd0, 24'd0);
    run_phase(FLOW_BOTH, 1'b1, 0, 24'd1, 24'd7, 24'd11);
    // long hold-off on the result side while requests keep coming
    run_phase(FLOW_FREE, 1'b1, HOLD_CYCLES, 24'd0, 24'd2, 24'd1);
    // widest settings, serial commands only so the mode waits never start;
    // a transfer begun here is still running when the next settings land
    run_phase(FLOW_FREE, 1'b0, 0, 24'd255, 24'hff_ffff, 24'hff_ffff);
    run_phase(FLOW_BOTH, 1'b1, 0, 24'd2, 24'd4, 24'd9);
    run_phase(FLOW_SEND_IDLE, 1'b1, 0, 24'd1, 24'd1, 24'd1);

    drain();
    repeat (8) @(posedge clk);
    if (pins_sb.failures == 0) begin
      $display("** lsb_first_spi_register_master: PASSED **");
    end else begin
      $display("** lsb_first_spi_register_master: FAILED **");
    end
    $finish;
  end

endmodule
